### hdl/rpa_pkg.sv
// Shared constants and the arctangent table of the sine/cosine pipeline.
package rpa_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int CORDIC_XW    = 34;
  localparam int CORDIC_ZW    = 21;
  localparam int SC_W         = 18;
  localparam int CORDIC_LAT   = CORDIC_STEPS + 2;

  localparam logic signed [CORDIC_XW-1:0] CORDIC_GAIN  = 34'sd652032874;
  localparam logic signed [16:0]          PI_Q13       = 17'sd25736;
  localparam logic signed [16:0]          TWO_PI_Q13   = 17'sd51472;
  localparam logic signed [CORDIC_ZW-1:0] HALF_PI_Q16  = 21'sd102944;
  localparam logic signed [CORDIC_ZW-1:0] PI_Q16       = 21'sd205887;

  function automatic logic signed [CORDIC_ZW-1:0] atan_q16(input int step);
    logic signed [CORDIC_ZW-1:0] v;
    case (step)
      0:  v = 21'sd51472;
      1:  v = 21'sd30385;
      2:  v = 21'sd16055;
      3:  v = 21'sd8150;
      4:  v = 21'sd4091;
      5:  v = 21'sd2047;
      6:  v = 21'sd1024;
      7:  v = 21'sd512;
      8:  v = 21'sd256;
      9:  v = 21'sd128;
      10: v = 21'sd64;
      11: v = 21'sd32;
      12: v = 21'sd16;
      13: v = 21'sd8;
      14: v = 21'sd4;
      15: v = 21'sd2;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

### hdl/rpa_cordic.sv
// Pipelined CORDIC sine and cosine, one iteration per stage, Q16 results.
module rpa_cordic import rpa_pkg::*; (
  input  logic                   clk,
  input  logic                   ce,
  input  logic signed [15:0]     angle,
  output logic signed [SC_W-1:0] cos_q16,
  output logic signed [SC_W-1:0] sin_q16
);

  logic signed [CORDIC_XW-1:0] x [0:CORDIC_STEPS];
  logic signed [CORDIC_XW-1:0] y [0:CORDIC_STEPS];
  logic signed [CORDIC_ZW-1:0] z [0:CORDIC_STEPS];
  logic                        neg [0:CORDIC_STEPS];

  logic signed [16:0]          a_wrap;
  logic signed [CORDIC_ZW-1:0] z_in;
  logic signed [CORDIC_ZW-1:0] z_fold;
  logic                        neg_fold;
  logic signed [CORDIC_XW-1:0] xf;
  logic signed [CORDIC_XW-1:0] yf;
  logic signed [CORDIC_XW-1:0] xr;
  logic signed [CORDIC_XW-1:0] yr;

  always_comb begin
    a_wrap = {angle[15], angle};
    if (a_wrap > PI_Q13) begin
      a_wrap = a_wrap - TWO_PI_Q13;
    end else if (a_wrap < -PI_Q13) begin
      a_wrap = a_wrap + TWO_PI_Q13;
    end
    z_in = {a_wrap[16], a_wrap, 3'b000};
    z_fold = z_in;
    neg_fold = 1'b0;
    if (z_in > HALF_PI_Q16) begin
      z_fold = z_in - PI_Q16;
      neg_fold = 1'b1;
    end else if (z_in < -HALF_PI_Q16) begin
      z_fold = z_in + PI_Q16;
      neg_fold = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      x[0]   <= CORDIC_GAIN;
      y[0]   <= '0;
      z[0]   <= z_fold;
      neg[0] <= neg_fold;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (ce) begin
        neg[i+1] <= neg[i];
        if (z[i] >= 0) begin
          x[i+1] <= x[i] - (y[i] >>> i);
          y[i+1] <= y[i] + (x[i] >>> i);
          z[i+1] <= z[i] - atan_q16(i);
        end else begin
          x[i+1] <= x[i] + (y[i] >>> i);
          y[i+1] <= y[i] - (x[i] >>> i);
          z[i+1] <= z[i] + atan_q16(i);
        end
      end
    end
  end

  always_comb begin
    xf = neg[CORDIC_STEPS] ? -x[CORDIC_STEPS] : x[CORDIC_STEPS];
    yf = neg[CORDIC_STEPS] ? -y[CORDIC_STEPS] : y[CORDIC_STEPS];
    xr = (xf + 34'sd8192) >>> 14;
    yr = (yf + 34'sd8192) >>> 14;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      cos_q16 <= xr[SC_W-1:0];
      sin_q16 <= yr[SC_W-1:0];
    end
  end

endmodule

### hdl/rotate_point_about_axis.sv
// Top level: rotates the eye-to-look direction about a unit axis and returns the new look point.
// Fully pipelined: one item per cycle; the pipeline is made up of the
// 16 one-iteration CORDIC stages followed by the matrix multiply, sum and saturate stages.
// A stall on the output holds the whole pipeline.
module rotate_point_about_axis import rpa_pkg::*; #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        s_tvalid,
  output logic                                        s_tready,
  // angle, axis_x, axis_y, axis_z, eye_x, eye_y, eye_z, look_x, look_y, look_z
  input  logic [((64 + 6 * COORD_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
  output logic                                        m_tvalid,
  input  logic                                        m_tready,
  // new_look_x, new_look_y, new_look_z
  output logic [((3 * COORD_WIDTH + 7) / 8) * 8 - 1:0]      m_tdata
);

  localparam int CW    = COORD_WIDTH;
  localparam int OUT_W = ((3 * CW + 7) / 8) * 8;
  localparam int L     = CORDIC_LAT;
  localparam int DW    = CW + 1;
  localparam int DHW   = DW - 16;
  localparam int EW    = 26;
  localparam int PHW   = EW + DHW;
  localparam int PLW   = EW + 17;
  localparam int HW    = PHW + 2;
  localparam int LW    = PLW + 2;
  localparam int RW    = HW + 2;

  logic ce;
  assign ce = !m_tvalid || m_tready;
  assign s_tready = ce;

  logic signed [15:0]   in_ax [0:2];
  logic signed [CW-1:0] in_eye [0:2];
  logic signed [DW-1:0] in_d [0:2];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      in_ax[k]  = s_tdata[16 + 16 * k +: 16];
      in_eye[k] = s_tdata[64 + CW * k +: CW];
      in_d[k]   = {s_tdata[64 + CW * (k + 3) + CW - 1], s_tdata[64 + CW * (k + 3) +: CW]}
                - {in_eye[k][CW-1], in_eye[k]};
    end
  end

  logic signed [SC_W-1:0] cos_q16;
  logic signed [SC_W-1:0] sin_q16;

  rpa_cordic u_cordic (
    .clk     (clk),
    .ce      (ce),
    .angle   (s_tdata[15:0]),
    .cos_q16 (cos_q16),
    .sin_q16 (sin_q16)
  );

  logic [L-1:0] vp;
  logic         va, vb, vc, vd, ve;

  always_ff @(posedge clk) begin
    if (rst) begin
      vp <= '0;
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      vd <= 1'b0;
      ve <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (ce) begin
      vp <= {vp[L-2:0], s_tvalid};
      va <= vp[L-1];
      vb <= va;
      vc <= vb;
      vd <= vc;
      ve <= vd;
      m_tvalid <= ve;
    end
  end

  logic signed [15:0]   ax_p  [0:L-1][0:2];
  logic signed [CW-1:0] eye_p [0:L-1][0:2];
  logic signed [DW-1:0] d_p   [0:L-1][0:2];

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int k = 0; k < 3; k++) begin
        ax_p[0][k]  <= in_ax[k];
        eye_p[0][k] <= in_eye[k];
        d_p[0][k]   <= in_d[k];
        for (int j = 1; j < L; j++) begin
          ax_p[j][k]  <= ax_p[j-1][k];
          eye_p[j][k] <= eye_p[j-1][k];
          d_p[j][k]   <= d_p[j-1][k];
        end
      end
    end
  end

  // stage A: axis products, t = 1 - c
  logic signed [18:0]   t_a;
  logic signed [SC_W-1:0] c_a;
  logic signed [31:0]   uv_a [0:5];
  logic signed [33:0]   us_a [0:2];
  logic signed [CW-1:0] eye_a [0:2];
  logic signed [DW-1:0] d_a [0:2];

  always_ff @(posedge clk) begin
    if (ce) begin
      t_a <= 19'sd65536 - {cos_q16[SC_W-1], cos_q16};
      c_a <= cos_q16;
      uv_a[0] <= 32'(ax_p[L-1][0]) * 32'(ax_p[L-1][0]);
      uv_a[1] <= 32'(ax_p[L-1][0]) * 32'(ax_p[L-1][1]);
      uv_a[2] <= 32'(ax_p[L-1][0]) * 32'(ax_p[L-1][2]);
      uv_a[3] <= 32'(ax_p[L-1][1]) * 32'(ax_p[L-1][1]);
      uv_a[4] <= 32'(ax_p[L-1][1]) * 32'(ax_p[L-1][2]);
      uv_a[5] <= 32'(ax_p[L-1][2]) * 32'(ax_p[L-1][2]);
      for (int k = 0; k < 3; k++) begin
        us_a[k]  <= 34'(ax_p[L-1][k]) * 34'(sin_q16);
        eye_a[k] <= eye_p[L-1][k];
        d_a[k]   <= d_p[L-1][k];
      end
    end
  end

  // stage B: (1-c)*u*v and u*s rounded to Q16
  logic signed [50:0]   tp [0:5];
  logic signed [50:0]   tq [0:5];
  logic signed [33:0]   sq [0:2];
  logic signed [23:0]   tuv_b [0:5];
  logic signed [19:0]   us_b [0:2];
  logic signed [SC_W-1:0] c_b;
  logic signed [CW-1:0] eye_b [0:2];
  logic signed [DW-1:0] d_b [0:2];

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      tp[k] = 51'(t_a) * 51'(uv_a[k]);
      tq[k] = (tp[k] + 51'sd134217728) >>> 28;
    end
    for (int k = 0; k < 3; k++) begin
      sq[k] = (us_a[k] + 34'sd8192) >>> 14;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      c_b <= c_a;
      for (int k = 0; k < 6; k++) begin
        tuv_b[k] <= tq[k][23:0];
      end
      for (int k = 0; k < 3; k++) begin
        us_b[k]  <= sq[k][19:0];
        eye_b[k] <= eye_a[k];
        d_b[k]   <= d_a[k];
      end
    end
  end

  // stage C: matrix entries
  logic signed [EW-1:0] ent [0:2][0:2];
  logic signed [CW-1:0] eye_c [0:2];
  logic signed [DW-1:0] d_c [0:2];

  always_ff @(posedge clk) begin
    if (ce) begin
      ent[0][0] <= EW'(c_b) + EW'(tuv_b[0]);
      ent[0][1] <= EW'(tuv_b[1]) - EW'(us_b[2]);
      ent[0][2] <= EW'(tuv_b[2]) + EW'(us_b[1]);
      ent[1][0] <= EW'(tuv_b[1]) + EW'(us_b[2]);
      ent[1][1] <= EW'(c_b) + EW'(tuv_b[3]);
      ent[1][2] <= EW'(tuv_b[4]) - EW'(us_b[0]);
      ent[2][0] <= EW'(tuv_b[2]) - EW'(us_b[1]);
      ent[2][1] <= EW'(tuv_b[4]) + EW'(us_b[0]);
      ent[2][2] <= EW'(c_b) + EW'(tuv_b[5]);
      for (int k = 0; k < 3; k++) begin
        eye_c[k] <= eye_b[k];
        d_c[k]   <= d_b[k];
      end
    end
  end

  // stage D: entry times split direction
  logic signed [DW-1:0]  dsh [0:2];
  logic signed [DHW-1:0] dh [0:2];
  logic signed [16:0]    dl [0:2];
  logic signed [PHW-1:0] ph [0:2][0:2];
  logic signed [PLW-1:0] pl [0:2][0:2];
  logic signed [CW-1:0]  eye_d [0:2];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dsh[k] = d_c[k] >>> 16;
      dh[k]  = dsh[k][DHW-1:0];
      dl[k]  = {1'b0, d_c[k][15:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int r = 0; r < 3; r++) begin
        eye_d[r] <= eye_c[r];
        for (int k = 0; k < 3; k++) begin
          ph[r][k] <= PHW'(ent[r][k]) * PHW'(dh[k]);
          pl[r][k] <= PLW'(ent[r][k]) * PLW'(dl[k]);
        end
      end
    end
  end

  // stage E: row sums
  logic signed [HW-1:0] hi [0:2];
  logic signed [LW-1:0] lo [0:2];
  logic signed [CW-1:0] eye_e [0:2];

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int r = 0; r < 3; r++) begin
        hi[r] <= HW'(ph[r][0]) + HW'(ph[r][1]) + HW'(ph[r][2]);
        lo[r] <= LW'(pl[r][0]) + LW'(pl[r][1]) + LW'(pl[r][2]);
        eye_e[r] <= eye_d[r];
      end
    end
  end

  // stage F: add eye, round, saturate
  logic signed [LW-1:0] lr [0:2];
  logic signed [RW-1:0] sum [0:2];
  logic [CW-1:0]        sat [0:2];
  logic [CW-1:0]        res [0:2];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      lr[r]  = (lo[r] + LW'(32768)) >>> 16;
      sum[r] = RW'(eye_e[r]) + RW'(hi[r]) + RW'(lr[r]);
      if ((&sum[r][RW-1:CW-1]) || !(|sum[r][RW-1:CW-1])) begin
        sat[r] = sum[r][CW-1:0];
      end else if (sum[r][RW-1]) begin
        sat[r] = {1'b1, {(CW-1){1'b0}}};
      end else begin
        sat[r] = {1'b0, {(CW-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int r = 0; r < 3; r++) begin
        res[r] <= sat[r];
      end
    end
  end

  assign m_tdata = OUT_W'({res[2], res[1], res[0]});

endmodule

### test/testbench.sv
// Testbench for rotate_point_about_axis: directed and random rotations checked against a local predictor.
module testbench;

  localparam int CW = 32;
  localparam int SW = ((64 + 6 * CW + 7) / 8) * 8;
  localparam int MW = ((3 * CW + 7) / 8) * 8;
  localparam int LIMIT = 5000;
  localparam int N_RANDOM = 1500;

  typedef struct {
    logic signed [15:0] angle;
    logic signed [15:0] ax, ay, az;
    logic signed [CW-1:0] ex, ey, ez;
    logic signed [CW-1:0] lx, ly, lz;
  } rot_item_t;

  typedef struct {
    logic [CW-1:0] nx, ny, nz;
  } look_t;

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [SW-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [MW-1:0] m_tdata;

  look_t pending_looks[$];
  int failures = 0;
  int idle_cycles = 0;
  int accepted = 0;
  int checked = 0;
  bit stim_done = 0;
  bit calm = 0;

  rotate_point_about_axis #(.COORD_WIDTH(CW)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint round_half_up(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic void sin_cos(input longint a13, output longint c16, output longint s16);
    longint x, y, z, nx;
    bit flip;
    longint atan_tab[16] = '{51472, 30385, 16055, 8150, 4091, 2047, 1024, 512,
                             256, 128, 64, 32, 16, 8, 4, 2};
    x = 652032874;
    y = 0;
    flip = 0;
    if (a13 > 25736) a13 -= 51472;
    else if (a13 < -25736) a13 += 51472;
    z = a13 * 8;
    if (z > 102944) begin
      z -= 205887;
      flip = 1;
    end else if (z < -102944) begin
      z += 205887;
      flip = 1;
    end
    for (int i = 0; i < 16; i++) begin
      if (z >= 0) begin
        nx = x - floor_shift(y, i);
        y = y + floor_shift(x, i);
        z -= atan_tab[i];
      end else begin
        nx = x + floor_shift(y, i);
        y = y - floor_shift(x, i);
        z += atan_tab[i];
      end
      x = nx;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    c16 = round_half_up(x, 14);
    s16 = round_half_up(y, 14);
  endfunction

  function automatic logic [CW-1:0] rotated_coord(longint eye, longint e0, longint e1,
                                                  longint e2, longint d[3]);
    longint hi, lo, r, row[3];
    longint maxv, minv;
    row = '{e0, e1, e2};
    maxv = (longint'(1) <<< (CW - 1)) - 1;
    minv = -maxv - 1;
    hi = 0;
    lo = 0;
    for (int k = 0; k < 3; k++) begin
      hi += row[k] * (d[k] >>> 16);
      lo += row[k] * (d[k] & 64'hFFFF);
    end
    r = eye + hi + round_half_up(lo, 16);
    if (r > maxv) r = maxv;
    if (r < minv) r = minv;
    return r[CW-1:0];
  endfunction

  function automatic look_t predict_look(rot_item_t it);
    longint c, s, t, x, y, z, d[3], eye[3];
    longint txx, txy, txz, tyy, tyz, tzz, sx, sy, sz;
    look_t r;
    sin_cos(longint'(it.angle), c, s);
    t = 65536 - c;
    x = it.ax;
    y = it.ay;
    z = it.az;
    eye = '{longint'(it.ex), longint'(it.ey), longint'(it.ez)};
    d[0] = longint'(it.lx) - eye[0];
    d[1] = longint'(it.ly) - eye[1];
    d[2] = longint'(it.lz) - eye[2];
    txx = round_half_up(t * x * x, 28);
    txy = round_half_up(t * x * y, 28);
    txz = round_half_up(t * x * z, 28);
    tyy = round_half_up(t * y * y, 28);
    tyz = round_half_up(t * y * z, 28);
    tzz = round_half_up(t * z * z, 28);
    sx = round_half_up(x * s, 14);
    sy = round_half_up(y * s, 14);
    sz = round_half_up(z * s, 14);
    r.nx = rotated_coord(eye[0], c + txx, txy - sz, txz + sy, d);
    r.ny = rotated_coord(eye[1], txy + sz, c + tyy, tyz - sx, d);
    r.nz = rotated_coord(eye[2], txz - sy, tyz + sx, c + tzz, d);
    return r;
  endfunction

  function automatic logic [SW-1:0] pack_item(rot_item_t it);
    logic [SW-1:0] v;
    v = '0;
    v[15:0] = it.angle;
    v[31:16] = it.ax;
    v[47:32] = it.ay;
    v[63:48] = it.az;
    v[64 + 0*CW +: CW] = it.ex;
    v[64 + 1*CW +: CW] = it.ey;
    v[64 + 2*CW +: CW] = it.ez;
    v[64 + 3*CW +: CW] = it.lx;
    v[64 + 4*CW +: CW] = it.ly;
    v[64 + 5*CW +: CW] = it.lz;
    return v;
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF - $urandom_range(0, 3);
      1: return 32'h8000_0000 + $urandom_range(0, 3);
      2: return $urandom_range(0, 32'h0FFF_FFFF) - 32'h0800_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic rot_item_t random_item();
    rot_item_t it;
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) it.angle = 16'($urandom);
    else if (sel == 1) it.angle = ($urandom_range(0, 1) ? 16'sd25736 : -16'sd25736);
    else it.angle = 16'($urandom_range(0, 51472) - 25736);
    sel = $urandom_range(0, 9);
    if (sel < 2) begin
      it.ax = 16'($urandom);
      it.ay = 16'($urandom);
      it.az = 16'($urandom);
    end else if (sel < 5) begin
      it.ax = 0;
      it.ay = 0;
      it.az = 0;
      case ($urandom_range(0, 2))
        0: it.ax = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
        1: it.ay = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
        default: it.az = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
      endcase
    end else begin
      it.ax = 16'($urandom_range(0, 18918) - 9459);
      it.ay = 16'($urandom_range(0, 18918) - 9459);
      it.az = 16'($urandom_range(0, 18918) - 9459);
    end
    it.ex = rand_coord();
    it.ey = rand_coord();
    it.ez = rand_coord();
    it.lx = rand_coord();
    it.ly = rand_coord();
    it.lz = rand_coord();
    return it;
  endfunction

  task automatic send_item(rot_item_t it);
    while (!calm && $urandom_range(0, 99) < 10) begin
      s_tvalid <= 0;
      @(negedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= pack_item(it);
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_looks.push_back(predict_look(it));
    accepted++;
    @(negedge clk);
  endtask

  // directed rows; fixed expectation only for the identity rotations
  typedef struct {
    rot_item_t it;
    bit fixed;
    look_t want;
  } row_t;

  row_t rows[$];

  task automatic add_row(logic signed [15:0] a, logic signed [15:0] x, logic signed [15:0] y,
                         logic signed [15:0] z, logic [31:0] e, logic [31:0] l, bit fixed);
    row_t r;
    r.it = '{a, x, y, z, e, e, e, l, l, l};
    r.fixed = fixed;
    r.want = '{l, l, l};
    rows.push_back(r);
  endtask

  initial begin
    add_row(0, 0, 0, 16384, 0, 0, 1);
    add_row(0, 0, 0, 16384, 32'h0001_0000, 32'h0005_0000, 0);
    add_row(16'sd25736, 0, 0, 16384, 0, 32'h0001_0000, 0);
    add_row(-16'sd25736, 16384, 0, 0, 0, 32'h0001_0000, 0);
    add_row(16'sd12868, 0, 16384, 0, 0, 32'h0002_0000, 0);
    add_row(-16'sd12868, 0, -16384, 0, 32'h0001_0000, 32'h0003_0000, 0);
    add_row(16'sh7FFF, 16384, 0, 0, 0, 32'h0001_0000, 0);
    add_row(16'sh8000, 0, 16384, 0, 0, 32'h0001_0000, 0);
    add_row(16'sd25737, 0, 0, -16384, 0, 32'h0001_0000, 0);
    add_row(-16'sd25737, 9459, 9459, 9459, 0, 32'h0001_0000, 0);
    add_row(16'sd12868, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 0, 32'h0001_0000, 0);
    add_row(16'sd12868, 16'sh8000, 16'sh8000, 16'sh8000, 0, 32'h0001_0000, 0);
    add_row(16'sd25736, 0, 0, 16384, 32'h7FFF_FFFF, 32'h8000_0000, 0);
    add_row(16'sd25736, 0, 0, 16384, 32'h8000_0000, 32'h7FFF_FFFF, 0);
    add_row(0, 16384, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1);
    add_row(0, 16384, 0, 0, 32'h8000_0000, 32'h8000_0000, 1);
    add_row(100, 1, -1, 2, 32'hFFFF_FFFF, 32'h0000_0001, 0);
    add_row(16'sd6434, 16'sd11585, 16'sd11585, 0, 32'h1234_5678, 32'hEDCB_A987, 0);
  end

  initial begin
    row_t r;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    for (int i = 0; i < rows.size(); i++) begin
      r = rows[i];
      send_item(r.it);
      if (r.fixed) pending_looks[$] = r.want;
    end
    for (int i = 0; i < N_RANDOM; i++) begin
      calm = (i >= 600 && i < 800);
      send_item(random_item());
    end
    s_tvalid <= 0;
    calm = 0;
    stim_done = 1;
  end

  always @(negedge clk) begin
    if (rst) m_tready <= 0;
    else m_tready <= calm || ($urandom_range(0, 99) >= 10);
  end

  always @(posedge clk) begin
    look_t want;
    logic [CW-1:0] gx, gy, gz;
    if (!rst && m_tvalid && m_tready) begin
      gx = m_tdata[0 +: CW];
      gy = m_tdata[CW +: CW];
      gz = m_tdata[2*CW +: CW];
      if (pending_looks.size() == 0) begin
        $error("result with no item pending: %h", m_tdata);
        failures++;
      end else begin
        want = pending_looks.pop_front();
        checked++;
        if (gx !== want.nx) begin
          $error("new_look_x expected %h got %h", want.nx, gx);
          failures++;
        end
        if (gy !== want.ny) begin
          $error("new_look_y expected %h got %h", want.ny, gy);
          failures++;
        end
        if (gz !== want.nz) begin
          $error("new_look_z expected %h got %h", want.nz, gz);
          failures++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    wait (stim_done);
    while (pending_looks.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("Rotated %0d points (%0d directed rows, rest random), %0d results compared.",
             accepted, rows.size(), checked);
    if (failures == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
